[hw/rtl/pcb_pkg.sv]
package pcb_pkg;

    localparam int POS_W = 22;
    localparam int FRAC_W = 20;
    localparam int ID_W = 16;
    localparam int REC_W = 17;
    localparam int CELL_W = 12;
    localparam int ADDR_W = 18;
    localparam int OCC_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 17;
    localparam int CELL_DEPTH = 4096;
    localparam int MAX_AXIS = 16;
    localparam int MAX_SLOT = 64;

    localparam logic [2:0] ST_STORED = 3'd0;
    localparam logic [2:0] ST_OVERFLOW = 3'd1;
    localparam logic [2:0] ST_NAN = 3'd2;
    localparam logic [2:0] ST_OUT_BOX = 3'd3;
    localparam logic [2:0] ST_GHOST = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIODIC = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_COUNT = 3'd5;

    typedef struct packed {
        logic                load_in;
        logic                clear_rec;
        logic                clr_we;
        logic [CELL_W-1:0]   clr_addr;
        logic                do_bin;
        logic                do_mula;
        logic                do_mulb;
        logic                do_adr;
        logic                do_upd;
        logic                out_load;
    } pcb_cmd_t;

    typedef struct packed {
        logic                ok;
        logic [3:0]          bin;
    } pcb_axis_t;

    function automatic logic [4:0] clamp_axis(input logic [4:0] d);
        logic [4:0] r;
        r = d;
        if (d == 5'd0)
        begin
            r = 5'd1;
        end
        else if (d > 5'(MAX_AXIS))
        begin
            r = 5'(MAX_AXIS);
        end
        return r;
    endfunction

    function automatic logic [6:0] clamp_slots(input logic [6:0] s);
        logic [6:0] r;
        r = s;
        if (s == 7'd0)
        begin
            r = 7'd1;
        end
        else if (s > 7'(MAX_SLOT))
        begin
            r = 7'(MAX_SLOT);
        end
        return r;
    endfunction

    function automatic pcb_axis_t axis_bin(input logic signed [POS_W-1:0] raw,
                                           input logic [4:0] dim,
                                           input logic per);
        pcb_axis_t  r;
        logic [26:0] p;
        logic [6:0]  b;
        logic        tol;
        tol = (raw >= -22'sd11) && (raw < 22'sd1048587);
        p = 27'(raw[POS_W-2:0]) * 27'(dim);
        b = (raw <= 22'sd0) ? 7'd0 : p[26:FRAC_W];
        if ((b == 7'(dim)) && per)
        begin
            b = 7'd0;
        end
        r.ok = tol && (b < 7'(dim));
        r.bin = b[3:0];
        return r;
    endfunction

endpackage

[hw/rtl/pcb_ctrl.sv]
module pcb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  logic             item_first,
    output pcb_pkg::pcb_cmd_t cmd
);
    import pcb_pkg::*;

    localparam logic [3:0] S_RCLR = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_ICLR = 4'd3;
    localparam logic [3:0] S_BIN  = 4'd4;
    localparam logic [3:0] S_MULA = 4'd5;
    localparam logic [3:0] S_MULB = 4'd6;
    localparam logic [3:0] S_ADR  = 4'd7;
    localparam logic [3:0] S_UPD  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [CELL_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cmd = '0;
        cmd.clr_addr = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_RCLR, S_ICLR:
            begin
                cmd.clr_we = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CELL_W'(CELL_DEPTH - 1))
                begin
                    state_next = (state_reg == S_RCLR) ? S_IDLE : S_BIN;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                cnt_next = '0;
                if (item_first)
                begin
                    cmd.clear_rec = 1'b1;
                    state_next = S_ICLR;
                end
                else
                begin
                    state_next = S_BIN;
                end
            end
            S_BIN:
            begin
                cmd.do_bin = 1'b1;
                state_next = S_MULA;
            end
            S_MULA:
            begin
                cmd.do_mula = 1'b1;
                state_next = S_MULB;
            end
            S_MULB:
            begin
                cmd.do_mulb = 1'b1;
                state_next = S_ADR;
            end
            S_ADR:
            begin
                cmd.do_adr = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.do_upd = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RCLR;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/pcb_dp.sv]
module pcb_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pcb_pkg::pcb_cmd_t                    cmd,
    output logic                                 item_first,
    input  logic                                 cfg_we,
    input  logic [pcb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pcb_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [pcb_pkg::POS_W-1:0]     frac_x,
    input  logic signed [pcb_pkg::POS_W-1:0]     frac_y,
    input  logic signed [pcb_pkg::POS_W-1:0]     frac_z,
    input  logic                                 position_nan,
    input  logic [pcb_pkg::ID_W-1:0]             particle_id,
    input  logic                                 first,
    input  logic                                 last,
    output logic [pcb_pkg::CELL_W-1:0]           cell_index,
    output logic [pcb_pkg::ADDR_W-1:0]           slot_address,
    output logic                                 store_valid,
    output logic [2:0]                           status,
    output logic [pcb_pkg::OCC_W-1:0]            overflow_need,
    output logic [pcb_pkg::REC_W-1:0]            nan_record,
    output logic [pcb_pkg::REC_W-1:0]            out_record,
    output logic                                 done_res
);
    import pcb_pkg::*;

    logic [4:0]  cx_reg, cy_reg, cz_reg;
    logic [6:0]  slots_cfg_reg;
    logic [2:0]  per_reg;
    logic [REC_W-1:0] local_reg;

    logic signed [POS_W-1:0] fx_reg, fy_reg, fz_reg;
    logic        nan_reg, first_reg, last_reg;
    logic [ID_W-1:0] id_reg;

    logic [4:0]  dx, dy, dz;
    logic [6:0]  slots;
    pcb_axis_t   ax, ay, az;
    logic [3:0]  ib_reg, jb_reg, kb_reg;
    logic        ok_reg;
    logic [7:0]  t_reg;
    logic [CELL_W-1:0] cell_reg;
    logic [ADDR_W-1:0] base_reg;

    logic [OCC_W-1:0] occ_mem [CELL_DEPTH];
    logic [OCC_W-1:0] q_reg;
    logic              mem_we;
    logic [CELL_W-1:0] mem_waddr;
    logic [OCC_W-1:0]  mem_wdata;

    logic [OCC_W-1:0] ovf_reg;
    logic [REC_W-1:0] nanr_reg, outr_reg;
    logic [CELL_W-1:0] rcell_reg;
    logic [ADDR_W-1:0] raddr_reg;
    logic              rstore_reg;
    logic [2:0]        rstat_reg;

    logic [OCC_W-1:0]  need;
    logic              fits;
    logic [REC_W-1:0]  id_plus;

    assign dx = clamp_axis(cx_reg);
    assign dy = clamp_axis(cy_reg);
    assign dz = clamp_axis(cz_reg);
    assign slots = clamp_slots(slots_cfg_reg);
    assign ax = axis_bin(fx_reg, dx, per_reg[0]);
    assign ay = axis_bin(fy_reg, dy, per_reg[1]);
    assign az = axis_bin(fz_reg, dz, per_reg[2]);
    assign item_first = first_reg;
    assign need = (q_reg == {OCC_W{1'b1}}) ? q_reg : q_reg + 1'b1;
    assign fits = (q_reg < OCC_W'(slots));
    assign id_plus = REC_W'(id_reg) + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= 5'd1;
            cy_reg <= 5'd1;
            cz_reg <= 5'd1;
            slots_cfg_reg <= 7'd1;
            per_reg <= 3'd7;
            local_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CELLS_X:     cx_reg <= cfg_data[4:0];
                REG_CELLS_Y:     cy_reg <= cfg_data[4:0];
                REG_CELLS_Z:     cz_reg <= cfg_data[4:0];
                REG_SLOTS:       slots_cfg_reg <= cfg_data[6:0];
                REG_PERIODIC:    per_reg <= cfg_data[2:0];
                REG_LOCAL_COUNT: local_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            fx_reg <= frac_x;
            fy_reg <= frac_y;
            fz_reg <= frac_z;
            nan_reg <= position_nan;
            id_reg <= particle_id;
            last_reg <= last;
        end
        if (cmd.do_bin)
        begin
            ib_reg <= ax.bin;
            jb_reg <= ay.bin;
            kb_reg <= az.bin;
            ok_reg <= ax.ok && ay.ok && az.ok;
        end
        if (cmd.do_mula)
        begin
            t_reg <= 8'(jb_reg) + 8'(dy) * 8'(kb_reg);
        end
        if (cmd.do_mulb)
        begin
            cell_reg <= CELL_W'(ib_reg) + CELL_W'(dx) * CELL_W'(t_reg);
        end
        if (cmd.do_adr)
        begin
            base_reg <= ADDR_W'(cell_reg) * ADDR_W'(slots);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b0;
        end
        else if (cmd.load_in)
        begin
            first_reg <= first;
        end
    end

    always_comb
    begin
        mem_we = cmd.clr_we;
        mem_waddr = cmd.clr_addr;
        mem_wdata = '0;
        if (cmd.do_upd && !nan_reg && ok_reg)
        begin
            mem_we = (q_reg != {OCC_W{1'b1}});
            mem_waddr = cell_reg;
            mem_wdata = q_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            occ_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.do_adr)
        begin
            q_reg <= occ_mem[cell_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg <= '0;
            nanr_reg <= '0;
            outr_reg <= '0;
        end
        else if (cmd.clear_rec)
        begin
            ovf_reg <= '0;
            nanr_reg <= '0;
            outr_reg <= '0;
        end
        else if (cmd.do_upd)
        begin
            if (nan_reg)
            begin
                nanr_reg <= id_plus;
            end
            else if (!ok_reg)
            begin
                if (REC_W'(id_reg) < local_reg)
                begin
                    outr_reg <= id_plus;
                end
            end
            else if (!fits && (need > ovf_reg))
            begin
                ovf_reg <= need;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_upd)
        begin
            rcell_reg <= '0;
            raddr_reg <= '0;
            rstore_reg <= 1'b0;
            if (nan_reg)
            begin
                rstat_reg <= ST_NAN;
            end
            else if (!ok_reg)
            begin
                rstat_reg <= (REC_W'(id_reg) < local_reg) ? ST_OUT_BOX : ST_GHOST;
            end
            else
            begin
                rcell_reg <= cell_reg;
                if (fits)
                begin
                    rstore_reg <= 1'b1;
                    raddr_reg <= base_reg + ADDR_W'(q_reg);
                    rstat_reg <= ST_STORED;
                end
                else
                begin
                    rstat_reg <= ST_OVERFLOW;
                end
            end
        end
        if (cmd.out_load)
        begin
            cell_index <= rcell_reg;
            slot_address <= raddr_reg;
            store_valid <= rstore_reg;
            status <= rstat_reg;
            overflow_need <= ovf_reg;
            nan_record <= nanr_reg;
            out_record <= outr_reg;
            done_res <= last_reg;
        end
    end

endmodule

[hw/rtl/particle_cell_binning_core.sv]
// Cell-list binning core. Each input beat carries one particle in signed
// Q2.20 fractional box coordinates with its id, a NaN flag and first/last
// segment marks. Each accepted beat yields exactly one output beat with the
// cell index, the payload slot address, a store strobe, a status code and
// the running overflow, NaN and out-of-box records.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. Configuration is written through cfg_we, cfg_index and
// cfg_data; the user writes it only while the core is idle, which the core does not enforce.
// One particle is processed at a time. After acceptance a particle passes the
// first-flag check, bin, two index multiply, address, counter read-modify-write
// and output steps before its result is registered; a new beat is taken only
// after the previous result has been registered.
// A beat with first set clears the 4096 occupancy counters one per cycle on
// the single memory port before binning. After reset the same clearing pass
// runs with in_stall high. A stalled output holds its beat, and the core
// waits with in_stall high until the result can be registered.
module particle_cell_binning_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [pcb_pkg::POS_W-1:0]     frac_x,
    input  logic signed [pcb_pkg::POS_W-1:0]     frac_y,
    input  logic signed [pcb_pkg::POS_W-1:0]     frac_z,
    input  logic                                 position_nan,
    input  logic [pcb_pkg::ID_W-1:0]             particle_id,
    input  logic                                 first,
    input  logic                                 last,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [pcb_pkg::CELL_W-1:0]           cell_index,
    output logic [pcb_pkg::ADDR_W-1:0]           slot_address,
    output logic                                 store_valid,
    output logic [2:0]                           status,
    output logic [pcb_pkg::OCC_W-1:0]            overflow_need,
    output logic [pcb_pkg::REC_W-1:0]            nan_record,
    output logic [pcb_pkg::REC_W-1:0]            out_record,
    output logic                                 done_res,
    input  logic                                 cfg_we,
    input  logic [pcb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pcb_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import pcb_pkg::*;

    pcb_cmd_t cmd;
    logic     item_first;

    pcb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .item_first (item_first),
        .cmd        (cmd)
    );

    pcb_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .item_first    (item_first),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .frac_x        (frac_x),
        .frac_y        (frac_y),
        .frac_z        (frac_z),
        .position_nan  (position_nan),
        .particle_id   (particle_id),
        .first         (first),
        .last          (last),
        .cell_index    (cell_index),
        .slot_address  (slot_address),
        .store_valid   (store_valid),
        .status        (status),
        .overflow_need (overflow_need),
        .nan_record    (nan_record),
        .out_record    (out_record),
        .done_res      (done_res)
    );

endmodule

[hw/rtl/pcb_checker.sv]
module pcb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [pcb_pkg::CELL_W-1:0]    cell_index,
    input logic [pcb_pkg::ADDR_W-1:0]    slot_address,
    input logic                          store_valid,
    input logic [2:0]                    status
);
    import pcb_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("core took a second beat right after the first");

    a_store_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (store_valid == (status == ST_STORED)))
        else $error("store strobe disagrees with status");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !store_valid |-> slot_address == '0)
        else $error("slot address set without a store");

    a_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NAN || status == ST_OUT_BOX || status == ST_GHOST)
        |-> cell_index == '0)
        else $error("cell index set for a particle that reached no cell");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot_address))
        else $error("stalled output beat changed");

endmodule

bind particle_cell_binning_core pcb_checker u_pcb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cell_index   (cell_index),
    .slot_address (slot_address),
    .store_valid  (store_valid),
    .status       (status)
);
